### src/random_permutation_shuffler_top_defines.svh
// Assertion macros for the permutation shuffler
`ifndef RANDOM_PERMUTATION_SHUFFLER_TOP_DEFINES_SVH
`define RANDOM_PERMUTATION_SHUFFLER_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset
`define RPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold at every clock edge outside reset
`define RPS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Condition in the cycle after an event
`define RPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rps_pkg.sv
// Types and constants for the permutation shuffler
`timescale 1ns / 1ps
`default_nettype none

package rps_pkg;

  localparam int WORD_W = 31;
  localparam int SIZE_W = 5;
  localparam int OUT_W  = 4;
  localparam int CNT_W  = $clog2(WORD_W);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(10);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD_J,
    ST_SWAP_I,
    ST_SWAP_J,
    ST_EMIT,
    ST_RD_0,
    ST_EMIT_0
  } rps_state_e;

endpackage

`default_nettype wire

### src/random_permutation_shuffler_top.sv
// Fisher-Yates permutation shuffler: modulo unit, index store and output stage
//
// Usage:
//   Each input transfer on in_* carries one 31-bit random word. The block
//   reduces it modulo (i+1) with a shift-subtract unit, one bit per cycle,
//   swaps store entries i and j and emits slot i on out_*, i counting down
//   from perm_size-1. The word for slot 1 also yields slot 0 with last_o set,
//   after which the store returns to identity for the next permutation.
//   Each word takes 31 modulo steps, one store read, two store writes and
//   one output load; the word for slot 1 also reads and loads slot 0.
//   in_stall_o is high while a word is in progress. A finished result sits
//   in the output register while out_stall_i is high; the next word is taken
//   meanwhile and its result waits until that register is free.
//   cfg_* writes perm_size (clamped to 2..MAX_SIZE), always ready; a write
//   restarts the permutation at once. The user is to make a write only while
//   idle; the block itself does not enforce it.
//   Reset: perm_size = 10, store at identity, no output pending.
`timescale 1ns / 1ps
`default_nettype none
`include "random_permutation_shuffler_top_defines.svh"

module random_permutation_shuffler_top
  import rps_pkg::*;
#(
  parameter int MAX_SIZE = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [WORD_W-1:0]   random_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [OUT_W-1:0]         position_o,
  output logic [OUT_W-1:0]         value_o,
  output logic                     last_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [SIZE_W-1:0]   cfg_perm_size_i
);

  localparam int IW = $clog2(MAX_SIZE);
  localparam int DW = $clog2(MAX_SIZE + 1);

  function automatic logic [IW-1:0] last_slot(input logic [SIZE_W-1:0] sz);
    logic [IW-1:0] r;
    if (int'(sz) < 2) begin
      r = IW'(1);
    end else if (int'(sz) > MAX_SIZE) begin
      r = IW'(MAX_SIZE - 1);
    end else begin
      r = IW'(int'(sz) - 1);
    end
    return r;
  endfunction

  rps_state_e          state_q, state_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [IW-1:0]       slot_q, slot_d;
  logic [WORD_W-1:0]   word_q, word_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DW-1:0]       rem_q, rem_d;
  logic [IW-1:0]       vi_q, vi_d;
  logic [IW-1:0]       vj_q, vj_d;
  logic [MAX_SIZE-1:0] mask_q, mask_d;

  logic [IW-1:0]       mem [MAX_SIZE];
  logic [IW-1:0]       rd_data_q;
  logic                rd_vld_q;
  logic [IW-1:0]       rd_idx_q;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [IW-1:0]       wr_data;
  logic [IW-1:0]       entry;

  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    pos_q, val_q;
  logic                last_q;
  logic                load;
  logic [IW-1:0]       ld_pos, ld_val;
  logic                ld_last;
  logic                out_free;
  logic                clr;

  logic [IW-1:0]       cur_last;
  logic [DW-1:0]       dvs;
  logic [DW:0]         trial;
  logic [DW-1:0]       rem_step;

  assign entry    = rd_vld_q ? rd_data_q : rd_idx_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cur_last = last_slot(size_q);
  assign dvs      = DW'(slot_q) + DW'(1);
  assign trial    = {rem_q, word_q[WORD_W-1]};
  assign rem_step = (trial >= {1'b0, dvs}) ? DW'(trial - {1'b0, dvs}) : DW'(trial);

  always_comb begin
    state_d = state_q;
    size_d  = size_q;
    slot_d  = slot_q;
    word_d  = word_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    vi_d    = vi_q;
    vj_d    = vj_q;
    clr     = 1'b0;
    wr_en   = 1'b0;
    wr_addr = slot_q;
    wr_data = vj_q;
    rd_addr = slot_q;
    load    = 1'b0;
    ld_pos  = slot_q;
    ld_val  = vj_q;
    ld_last = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          word_d  = random_word_i;
          cnt_d   = '0;
          rem_d   = '0;
          state_d = ST_DIV;
          if (slot_q == '0 || slot_q > cur_last) begin
            clr    = 1'b1;
            slot_d = cur_last;
          end
        end
      end
      ST_DIV: begin
        rem_d  = rem_step;
        word_d = word_q << 1;
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WORD_W - 1)) begin
          state_d = ST_RD_J;
        end
      end
      ST_RD_J: begin
        rd_addr = rem_q[IW-1:0];
        vi_d    = entry;
        state_d = ST_SWAP_I;
      end
      ST_SWAP_I: begin
        vj_d    = entry;
        wr_en   = 1'b1;
        wr_addr = slot_q;
        wr_data = entry;
        state_d = ST_SWAP_J;
      end
      ST_SWAP_J: begin
        wr_en   = 1'b1;
        wr_addr = rem_q[IW-1:0];
        wr_data = vi_q;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (slot_q == IW'(1)) begin
            state_d = ST_RD_0;
          end else begin
            slot_d  = slot_q - IW'(1);
            state_d = ST_IDLE;
          end
        end
      end
      ST_RD_0: begin
        rd_addr = '0;
        state_d = ST_EMIT_0;
      end
      ST_EMIT_0: begin
        rd_addr = '0;
        if (out_free) begin
          load    = 1'b1;
          ld_pos  = '0;
          ld_val  = entry;
          ld_last = 1'b1;
          clr     = 1'b1;
          slot_d  = cur_last;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register write restarts the permutation
    if (cfg_valid_i) begin
      size_d = cfg_perm_size_i;
      slot_d = last_slot(cfg_perm_size_i);
      clr    = 1'b1;
    end

    mask_d = clr ? '0 : mask_q;
    if (wr_en) begin
      mask_d[wr_addr] = 1'b1;
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= SIZE_RESET;
      slot_q      <= last_slot(SIZE_RESET);
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      slot_q      <= slot_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    vi_q   <= vi_d;
    vj_q   <= vj_d;
    if (load) begin
      pos_q  <= OUT_W'(ld_pos);
      val_q  <= OUT_W'(ld_val);
      last_q <= ld_last;
    end
  end

  // index store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= mask_q[rd_addr];
    rd_idx_q  <= rd_addr;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign value_o     = val_q;
  assign last_o      = last_q;

  `RPS_ASSERT_IMP(a_last_slot_zero, out_valid_o && last_o, position_o == '0, "last on nonzero slot")
  `RPS_ASSERT_ALWAYS(a_slot_nonzero, slot_q != '0, "current slot reached zero")
  `RPS_ASSERT_NEXT(a_accept_starts_div, in_valid_i && !in_stall_o, state_q == ST_DIV, "no modulo after transfer")

endmodule

`default_nettype wire
